/* src/banhs_pkg.sv */
// Shared types and constants for the battery-aware next-hop selector.
package banhs_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] CMD_ANNOUNCE  = 2'd0;
  localparam logic [1:0] CMD_SELECT    = 2'd1;
  localparam logic [1:0] CMD_ADVERTISE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REACHES_SINK      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_IS_SINK      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SINK_ADDRESS      = 2'd3;

  localparam logic [15:0] RST_BATTERY_THRESHOLD = 16'd50;
  localparam logic [15:0] RST_SINK_ADDRESS      = 16'd1;
  localparam logic [15:0] HOP_CAP               = 16'd900;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] neighbor_address;
    logic        neighbor_is_closer;
    logic [15:0] neighbor_battery;
    logic [15:0] neighbor_hops;
    logic [6:0]  own_battery_percent;
  } in_item_t;

  typedef struct packed {
    logic [15:0] router_address;
    logic        router_valid;
    logic [15:0] announce_battery;
    logic [15:0] announce_hops;
    logic        table_dropped;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic idx_clr;
    logic idx_inc;
    logic tbl_wr_idx;
    logic tbl_wr_new;
    logic set_drop;
    logic sel_sink;
    logic p1_step;
    logic p2_init;
    logic p2_step;
    logic commit;
    logic reply;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       closer;
    logic       is_sink;
    logic       reaches_sink;
    logic       tbl_empty;
    logic       tbl_full;
    logic       last;
    logic       addr_match;
    logic       best_gt_thr;
  } dp_sts_t;

endpackage

/* src/banhs_ctrl.sv */
// Sequencing state machine for the next-hop selector.
module banhs_ctrl
  import banhs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  input  dp_sts_t sts,
  output dp_cmd_t dp_cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_ANN      = 3'd2;
  localparam logic [2:0] ST_P1       = 3'd3;
  localparam logic [2:0] ST_CHK      = 3'd4;
  localparam logic [2:0] ST_P2       = 3'd5;
  localparam logic [2:0] ST_COMMIT   = 3'd6;
  localparam logic [2:0] ST_REPLY    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r;

  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          dp_cmd.load_item = 1'b1;
          state_nxt        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = ST_REPLY;
        unique case (sts.cmd)
          CMD_ANNOUNCE: begin
            if (!sts.is_sink && sts.closer) begin
              if (sts.tbl_empty) dp_cmd.tbl_wr_new = 1'b1;
              else state_nxt = ST_ANN;
            end
          end
          CMD_SELECT: begin
            if (!sts.is_sink) begin
              if (sts.reaches_sink) dp_cmd.sel_sink = 1'b1;
              else if (!sts.tbl_empty) state_nxt = ST_P1;
            end
          end
          default: ;
        endcase
      end
      ST_ANN: begin
        if (sts.addr_match) begin
          dp_cmd.tbl_wr_idx = 1'b1;
          state_nxt         = ST_REPLY;
        end else if (sts.last) begin
          if (sts.tbl_full) dp_cmd.set_drop = 1'b1;
          else dp_cmd.tbl_wr_new = 1'b1;
          state_nxt = ST_REPLY;
        end else begin
          dp_cmd.idx_inc = 1'b1;
        end
      end
      ST_P1: begin
        dp_cmd.p1_step = 1'b1;
        if (sts.last) begin
          dp_cmd.idx_clr = 1'b1;
          state_nxt      = ST_CHK;
        end else begin
          dp_cmd.idx_inc = 1'b1;
        end
      end
      ST_CHK: begin
        // The hop-count pass runs only when the best battery beats the threshold.
        if (sts.best_gt_thr) begin
          dp_cmd.p2_init = 1'b1;
          state_nxt      = ST_P2;
        end else begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_P2: begin
        dp_cmd.p2_step = 1'b1;
        if (sts.last) state_nxt = ST_COMMIT;
        else dp_cmd.idx_inc = 1'b1;
      end
      ST_COMMIT: begin
        dp_cmd.commit = 1'b1;
        state_nxt     = ST_REPLY;
      end
      ST_REPLY: begin
        dp_cmd.reply = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_REPLY);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* src/banhs_dp.sv */
// Datapath: configuration, neighbor table, scan registers and result register.
module banhs_dp
  import banhs_pkg::*;
#(
  parameter int TABLE_ENTRIES = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_cmd_t               dp_cmd,
  output dp_sts_t               sts
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [15:0] thr_r;
  logic        reaches_sink_r;
  logic        is_sink_r;
  logic [15:0] sink_addr_r;

  logic [15:0] ent_addr_r [TABLE_ENTRIES];
  logic [15:0] ent_bat_r  [TABLE_ENTRIES];
  logic [15:0] ent_hops_r [TABLE_ENTRIES];

  // Entries fill in order and are never freed, so a count marks the used ones.
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  in_item_t         item_r, item_nxt;
  logic             drop_r, drop_nxt;
  logic [15:0]      best_r, best_nxt;
  logic [15:0]      fewest_r, fewest_nxt;
  logic [15:0]      pick_addr_r, pick_addr_nxt;
  logic [15:0]      pick_bat_r, pick_bat_nxt;
  logic [15:0]      pick_hops_r, pick_hops_nxt;
  logic [15:0]      next_hop_r, next_hop_nxt;
  logic [15:0]      path_bat_r, path_bat_nxt;
  logic [15:0]      path_hops_r, path_hops_nxt;
  out_item_t        out_r, out_nxt;

  logic [15:0]      rd_addr, rd_bat, rd_hops;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_en;
  logic             tbl_full;

  assign rd_addr  = ent_addr_r[idx_r];
  assign rd_bat   = ent_bat_r[idx_r];
  assign rd_hops  = ent_hops_r[idx_r];
  assign tbl_full = (fill_r == CNT_W'(TABLE_ENTRIES));
  assign wr_en    = dp_cmd.tbl_wr_idx | dp_cmd.tbl_wr_new;
  assign wr_idx   = dp_cmd.tbl_wr_new ? fill_r[IDX_W-1:0] : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r          <= RST_BATTERY_THRESHOLD;
      reaches_sink_r <= 1'b0;
      is_sink_r      <= 1'b0;
      sink_addr_r    <= RST_SINK_ADDRESS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BATTERY_THRESHOLD: thr_r          <= cfg_wdata;
        REG_REACHES_SINK:      reaches_sink_r <= cfg_wdata[0];
        REG_NODE_IS_SINK:      is_sink_r      <= cfg_wdata[0];
        REG_SINK_ADDRESS:      sink_addr_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_addr_r[wr_idx] <= item_r.neighbor_address;
      ent_bat_r[wr_idx]  <= item_r.neighbor_battery;
      ent_hops_r[wr_idx] <= item_r.neighbor_hops;
    end
  end

  always_comb begin
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    item_nxt      = item_r;
    drop_nxt      = drop_r;
    best_nxt      = best_r;
    fewest_nxt    = fewest_r;
    pick_addr_nxt = pick_addr_r;
    pick_bat_nxt  = pick_bat_r;
    pick_hops_nxt = pick_hops_r;
    next_hop_nxt  = next_hop_r;
    path_bat_nxt  = path_bat_r;
    path_hops_nxt = path_hops_r;
    out_nxt       = out_r;

    if (dp_cmd.load_item) begin
      item_nxt = in_item;
      drop_nxt = 1'b0;
    end
    if (dp_cmd.load_item || dp_cmd.idx_clr) idx_nxt = '0;
    else if (dp_cmd.idx_inc) idx_nxt = idx_r + IDX_W'(1);
    if (dp_cmd.tbl_wr_new) fill_nxt = fill_r + CNT_W'(1);
    if (dp_cmd.set_drop) drop_nxt = 1'b1;
    if (dp_cmd.sel_sink) next_hop_nxt = sink_addr_r;

    // Entry 0 seeds the pick, so an all-zero table still selects it.
    if (dp_cmd.p1_step && ((idx_r == '0) || (rd_bat > best_r))) begin
      best_nxt      = rd_bat;
      pick_addr_nxt = rd_addr;
      pick_bat_nxt  = rd_bat;
      pick_hops_nxt = rd_hops;
    end
    if (dp_cmd.p2_init) fewest_nxt = HOP_CAP;
    if (dp_cmd.p2_step && (rd_hops < fewest_r) && (rd_bat > thr_r)) begin
      fewest_nxt    = rd_hops;
      pick_addr_nxt = rd_addr;
      pick_bat_nxt  = rd_bat;
      pick_hops_nxt = rd_hops;
    end
    if (dp_cmd.commit) begin
      next_hop_nxt  = pick_addr_r;
      path_bat_nxt  = pick_bat_r;
      path_hops_nxt = pick_hops_r;
    end

    if (dp_cmd.reply) begin
      out_nxt.router_address   = next_hop_r;
      out_nxt.router_valid     = (next_hop_r != '0);
      out_nxt.table_dropped    = drop_r;
      out_nxt.announce_battery = '0;
      out_nxt.announce_hops    = '0;
      if (item_r.cmd == CMD_ADVERTISE) begin
        if (is_sink_r || reaches_sink_r || ({9'd0, item_r.own_battery_percent} < path_bat_r))
          out_nxt.announce_battery = {9'd0, item_r.own_battery_percent};
        else
          out_nxt.announce_battery = path_bat_r;
        if (is_sink_r) out_nxt.announce_hops = '0;
        else if (reaches_sink_r) out_nxt.announce_hops = 16'd1;
        else out_nxt.announce_hops = path_hops_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      next_hop_r  <= '0;
      path_bat_r  <= '0;
      path_hops_r <= '0;
    end else begin
      fill_r      <= fill_nxt;
      next_hop_r  <= next_hop_nxt;
      path_bat_r  <= path_bat_nxt;
      path_hops_r <= path_hops_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    item_r      <= item_nxt;
    drop_r      <= drop_nxt;
    best_r      <= best_nxt;
    fewest_r    <= fewest_nxt;
    pick_addr_r <= pick_addr_nxt;
    pick_bat_r  <= pick_bat_nxt;
    pick_hops_r <= pick_hops_nxt;
    out_r       <= out_nxt;
  end

  always_comb begin
    sts              = '0;
    sts.cmd          = item_r.cmd;
    sts.closer       = item_r.neighbor_is_closer;
    sts.is_sink      = is_sink_r;
    sts.reaches_sink = reaches_sink_r;
    sts.tbl_empty    = (fill_r == '0);
    sts.tbl_full     = tbl_full;
    sts.last         = ((CNT_W'(idx_r) + CNT_W'(1)) == fill_r);
    sts.addr_match   = (rd_addr == item_r.neighbor_address);
    sts.best_gt_thr  = (best_r > thr_r);
  end

  assign out_item = out_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.tbl_wr_new |-> !tbl_full)
    else $error("new entry written into a full table");

endmodule

/* src/battery_aware_next_hop_selector_core.sv */
// Top level: one item in flight; an item that needs no table walk goes from accept to
// result strobe through the dispatch and reply states, a heard announcement may also
// walk the filled entries once and a selection up to twice (one entry read per cycle).
// A new item may be accepted in the cycle its predecessor's result is shown.
// Synchronous active-low reset clears the table count, the route and the configuration
// to their defaults; results are strobed for one cycle and cannot be stalled.
module battery_aware_next_hop_selector_core
  import banhs_pkg::*;
#(
  parameter int TABLE_ENTRIES = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t dp_cmd;
  dp_sts_t sts;

  banhs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .dp_cmd    (dp_cmd)
  );

  banhs_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .dp_cmd    (dp_cmd),
    .sts       (sts)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

endmodule

/* tb/battery_aware_next_hop_selector_core_tb.sv */
// Self-checking testbench for the battery-aware next-hop selector core.
module battery_aware_next_hop_selector_core_tb
  import banhs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = 12;
  localparam int POOL_SIZE     = 20;
  localparam int PHASES        = 13;
  localparam int PHASE_ITEMS   = 100;
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              stim;
    bit                    typed;
    out_item_t             want;
  } plan_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  in_item_t              in_item   = '0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  busy;
  logic                  out_valid;
  out_item_t             out_item;

  // Predictor copy of the neighbor table, the route and the registers.
  bit          nbr_used [TABLE_ENTRIES];
  logic [15:0] nbr_addr [TABLE_ENTRIES];
  logic [15:0] nbr_bat  [TABLE_ENTRIES];
  logic [15:0] nbr_hops [TABLE_ENTRIES];
  logic [15:0] route_addr  = '0;
  logic [15:0] route_bat   = '0;
  logic [15:0] route_hops  = '0;
  logic [15:0] thr_q       = RST_BATTERY_THRESHOLD;
  logic        reaches_q   = 1'b0;
  logic        is_sink_q   = 1'b0;
  logic [15:0] sink_addr_q = RST_SINK_ADDRESS;

  out_item_t   owed_replies [$];
  out_item_t   head;
  plan_row_t   plan [$];
  int unsigned mismatches = 0;

  battery_aware_next_hop_selector_core #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    #(12_000_000);
    $display("FAILURE");
    $finish;
  end

  function automatic out_item_t route_step(in_item_t it);
    out_item_t   r;
    int          k;
    int          pick;
    bit          taken;
    logic [15:0] top_bat;
    logic [15:0] fewest;
    r = '0;
    case (it.cmd)
      CMD_ANNOUNCE: begin
        if (!is_sink_q && it.neighbor_is_closer) begin
          taken = 1'b0;
          for (k = 0; k < TABLE_ENTRIES && !taken; k++) begin
            if (!nbr_used[k] || nbr_addr[k] == it.neighbor_address) begin
              nbr_used[k] = 1'b1;
              nbr_addr[k] = it.neighbor_address;
              nbr_bat[k]  = it.neighbor_battery;
              nbr_hops[k] = it.neighbor_hops;
              taken = 1'b1;
            end
          end
          r.table_dropped = !taken;
        end
      end
      CMD_SELECT: begin
        if (!is_sink_q) begin
          if (reaches_q) begin
            route_addr = sink_addr_q;
          end else if (nbr_used[0]) begin
            pick = 0;
            top_bat = '0;
            for (k = 0; k < TABLE_ENTRIES && nbr_used[k]; k++) begin
              if (nbr_bat[k] > top_bat) begin
                top_bat = nbr_bat[k];
                pick = k;
              end
            end
            // A strong enough best entry switches the ranking to hop count.
            if (top_bat > thr_q) begin
              fewest = HOP_CAP;
              for (k = 0; k < TABLE_ENTRIES && nbr_used[k]; k++) begin
                if (nbr_hops[k] < fewest && nbr_bat[k] > thr_q) begin
                  fewest = nbr_hops[k];
                  pick = k;
                end
              end
            end
            route_bat  = nbr_bat[pick];
            route_hops = nbr_hops[pick];
            route_addr = nbr_addr[pick];
          end
        end
      end
      CMD_ADVERTISE: begin
        if (is_sink_q || reaches_q || it.own_battery_percent < route_bat) begin
          r.announce_battery = 16'(it.own_battery_percent);
        end else begin
          r.announce_battery = route_bat;
        end
        if (is_sink_q) begin
          r.announce_hops = '0;
        end else if (reaches_q) begin
          r.announce_hops = 16'd1;
        end else begin
          r.announce_hops = route_hops;
        end
      end
      default: ;
    endcase
    r.router_address = route_addr;
    r.router_valid   = (route_addr != '0);
    return r;
  endfunction

  function automatic in_item_t mk_item(logic [1:0] c, logic [15:0] a, logic cl,
                                       logic [15:0] b, logic [15:0] h, logic [6:0] o);
    in_item_t s;
    s.cmd                 = c;
    s.neighbor_address    = a;
    s.neighbor_is_closer  = cl;
    s.neighbor_battery    = b;
    s.neighbor_hops       = h;
    s.own_battery_percent = o;
    return s;
  endfunction

  function automatic plan_row_t row_known(in_item_t s, out_item_t w);
    plan_row_t row;
    row = '{is_write: 1'b0, reg_sel: '0, reg_val: '0, stim: s, typed: 1'b1, want: w};
    return row;
  endfunction

  function automatic plan_row_t row_item(in_item_t s);
    plan_row_t row;
    row = row_known(s, '0);
    row.typed = 1'b0;
    return row;
  endfunction

  function automatic plan_row_t row_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    plan_row_t row;
    row = row_known('0, '0);
    row.is_write = 1'b1;
    row.reg_sel  = idx;
    row.reg_val  = val;
    return row;
  endfunction

  task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Drives one item and waits until the block is no longer busy, then books the expected reply.
  task automatic issue(in_item_t it, bit typed, out_item_t want);
    out_item_t predicted;
    in_item <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = route_step(it);
    owed_replies.push_back(typed ? want : predicted);
  endtask

  task automatic rest(bit burst);
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    if (burst || r < 45) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BATTERY_THRESHOLD: thr_q       = val;
      REG_REACHES_SINK:      reaches_q   = val[0];
      REG_NODE_IS_SINK:      is_sink_q   = val[0];
      REG_SINK_ADDRESS:      sink_addr_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (owed_replies.size() == 0) begin
        note_mismatch("result with nothing outstanding", out_item.router_address, '0);
      end else begin
        head = owed_replies.pop_front();
        if (out_item.router_address !== head.router_address)
          note_mismatch("router_address", out_item.router_address, head.router_address);
        if (out_item.router_valid !== head.router_valid)
          note_mismatch("router_valid", 16'(out_item.router_valid), 16'(head.router_valid));
        if (out_item.announce_battery !== head.announce_battery)
          note_mismatch("announce_battery", out_item.announce_battery,
                        head.announce_battery);
        if (out_item.announce_hops !== head.announce_hops)
          note_mismatch("announce_hops", out_item.announce_hops, head.announce_hops);
        if (out_item.table_dropped !== head.table_dropped)
          note_mismatch("table_dropped", 16'(out_item.table_dropped),
                        16'(head.table_dropped));
      end
    end
  end

  initial begin
    in_item_t    it;
    int unsigned r;
    int unsigned lim;
    int unsigned n;
    int          p;
    int          k;
    bit          burst;
    logic [15:0] thr_pick;
    logic [15:0] saddr;
    logic [15:0] addr_pool [POOL_SIZE];

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset state, extremes and the special cases of selection.
    plan.push_back(row_known(mk_item(CMD_SELECT, 16'h0, 1'b0, 16'h0, 16'h0, 7'd0), '0));
    // Path battery is still zero, so zero is advertised.
    plan.push_back(row_known(mk_item(CMD_ADVERTISE, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF,
                                     7'd100), '0));
    plan.push_back(row_known(mk_item(CMD_ANNOUNCE, 16'h1234, 1'b0, 16'hFFFF, 16'h0,
                                     7'd0), '0));
    plan.push_back(row_known(mk_item(CMD_ANNOUNCE, 16'hFFFF, 1'b1, 16'h0, 16'hFFFF,
                                     7'h7F), '0));
    // With every battery at zero the first entry wins.
    plan.push_back(row_known(mk_item(CMD_SELECT, 16'h0, 1'b0, 16'h0, 16'h0, 7'd0),
                             out_item_t'{16'hFFFF, 1'b1, 16'h0, 16'h0, 1'b0}));
    plan.push_back(row_item(mk_item(CMD_ANNOUNCE, 16'h0000, 1'b1, 16'hFFFF, HOP_CAP,
                                    7'd0)));
    plan.push_back(row_item(mk_item(CMD_ANNOUNCE, 16'h0010, 1'b1, 16'd51, 16'd899,
                                    7'd0)));
    plan.push_back(row_item(mk_item(CMD_SELECT, 16'h0, 1'b0, 16'h0, 16'h0, 7'd0)));
    plan.push_back(row_item(mk_item(CMD_ADVERTISE, 16'h0, 1'b0, 16'h0, 16'h0, 7'd127)));
    plan.push_back(row_item(mk_item(CMD_ADVERTISE, 16'h0, 1'b0, 16'h0, 16'h0, 7'd7)));
    // Nothing can exceed the top threshold, so the strongest entry (address 0) wins.
    plan.push_back(row_write(REG_BATTERY_THRESHOLD, 16'hFFFF));
    plan.push_back(row_known(mk_item(CMD_SELECT, 16'h0, 1'b0, 16'h0, 16'h0, 7'd0), '0));
    plan.push_back(row_write(REG_BATTERY_THRESHOLD, 16'h0000));
    plan.push_back(row_item(mk_item(CMD_ANNOUNCE, 16'h0010, 1'b1, 16'd9, 16'h0, 7'd0)));
    plan.push_back(row_item(mk_item(CMD_SELECT, 16'h0, 1'b0, 16'h0, 16'h0, 7'd0)));
    plan.push_back(row_write(REG_SINK_ADDRESS, 16'hFFFF));
    plan.push_back(row_write(REG_REACHES_SINK, 16'd1));
    plan.push_back(row_known(mk_item(CMD_SELECT, 16'h0, 1'b0, 16'h0, 16'h0, 7'd0),
                             out_item_t'{16'hFFFF, 1'b1, 16'h0, 16'h0, 1'b0}));
    plan.push_back(row_known(mk_item(CMD_ADVERTISE, 16'h0, 1'b0, 16'h0, 16'h0, 7'd100),
                             out_item_t'{16'hFFFF, 1'b1, 16'd100, 16'd1, 1'b0}));
    plan.push_back(row_write(REG_NODE_IS_SINK, 16'd1));
    plan.push_back(row_write(REG_REACHES_SINK, 16'd0));
    plan.push_back(row_item(mk_item(CMD_ANNOUNCE, 16'h0077, 1'b1, 16'hFFFF, 16'd1,
                                    7'd0)));
    plan.push_back(row_item(mk_item(CMD_SELECT, 16'h0, 1'b0, 16'h0, 16'h0, 7'd0)));
    plan.push_back(row_known(mk_item(CMD_ADVERTISE, 16'h0, 1'b0, 16'h0, 16'h0, 7'd0),
                             out_item_t'{16'hFFFF, 1'b1, 16'h0, 16'h0, 1'b0}));
    plan.push_back(row_known(mk_item(CMD_NONE, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF,
                                     7'h7F), out_item_t'{16'hFFFF, 1'b1, 16'h0, 16'h0,
                                                         1'b0}));

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        quiesce();
        set_reg(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        issue(plan[i].stim, plan[i].typed, plan[i].want);
        rest(1'b0);
      end
    end

    // Random part. Addresses come from a pool that widens slowly, so selections
    // see the table at every fill level before it saturates and starts dropping.
    addr_pool[0] = 16'hFFFF;
    addr_pool[1] = 16'h0000;
    addr_pool[2] = 16'h0010;
    for (k = 3; k < POOL_SIZE; k++) addr_pool[k] = 16'($urandom);
    n = 0;
    for (p = 0; p < PHASES; p++) begin
      quiesce();
      case (p % 5)
        0: thr_pick = 16'h0000;
        1: thr_pick = 16'hFFFF;
        2: thr_pick = RST_BATTERY_THRESHOLD;
        3: thr_pick = 16'($urandom_range(0, 2000));
        default: thr_pick = 16'($urandom);
      endcase
      if (p == 0) saddr = RST_SINK_ADDRESS;
      else if (p == 1) saddr = 16'hFFFF;
      else saddr = 16'($urandom_range(1, 65535));
      set_reg(REG_BATTERY_THRESHOLD, thr_pick);
      set_reg(REG_REACHES_SINK, (p % 4 == 3) ? 16'd1 : 16'd0);
      set_reg(REG_NODE_IS_SINK, (p % 6 == 5) ? 16'd1 : 16'd0);
      set_reg(REG_SINK_ADDRESS, saddr);
      burst = (p % 3 == 2);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 48) it.cmd = CMD_ANNOUNCE;
        else if (r < 74) it.cmd = CMD_SELECT;
        else if (r < 96) it.cmd = CMD_ADVERTISE;
        else it.cmd = CMD_NONE;

        lim = (3 + n / 50 < POOL_SIZE - 1) ? 3 + n / 50 : POOL_SIZE - 1;
        if ($urandom_range(0, 99) < 5) it.neighbor_address = 16'($urandom);
        else it.neighbor_address = addr_pool[$urandom_range(0, lim)];
        it.neighbor_is_closer = ($urandom_range(0, 99) < 85);

        r = $urandom_range(0, 99);
        if (r < 5) it.neighbor_battery = 16'h0000;
        else if (r < 10) it.neighbor_battery = 16'hFFFF;
        else if (r < 50) it.neighbor_battery = thr_q + 16'($urandom_range(0, 4)) - 16'd2;
        else if (r < 75) it.neighbor_battery = 16'($urandom_range(0, 3000));
        else it.neighbor_battery = 16'($urandom);

        r = $urandom_range(0, 99);
        if (r < 5) it.neighbor_hops = 16'h0000;
        else if (r < 10) it.neighbor_hops = 16'hFFFF;
        else if (r < 30) it.neighbor_hops = HOP_CAP + 16'($urandom_range(0, 4)) - 16'd2;
        else if (r < 80) it.neighbor_hops = 16'($urandom_range(0, 1000));
        else it.neighbor_hops = 16'($urandom);

        if ($urandom_range(0, 99) < 20) it.own_battery_percent = 7'($urandom_range(101, 127));
        else it.own_battery_percent = 7'($urandom_range(0, 100));

        issue(it, 1'b0, '0);
        n++;
        rest(burst);
      end
    end

    quiesce();
    // A selection walks the table up to twice; leave room for a stray late result.
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
